// File: src/brap_pkg.sv
// Package of the Brownian active particle step unit: item types, fixed-point
// constants, the CORDIC arctangent table and the saturation helper.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
package brap_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int QUEUE_DEPTH_DEF   = 4;
   localparam int CORDIC_MAX        = 32;

   // Angle reduction: the angle magnitude stays below 2*pi * 2^REDUCE_STEPS.
   localparam int REDUCE_STEPS = 13;
   localparam int ZW = 48;   // angle after the product, Q.30
   localparam int AW = 36;   // reduced angle and CORDIC residual, Q.30
   localparam int XW = 49;   // CORDIC vector with guard bits
   localparam int DW = 50;   // displacement, Q16.16

   localparam logic [ZW-1:0]        FX_TWO_PI  = 48'd6746518852;
   localparam logic signed [AW-1:0] FX_TWO_PI_S = 36'sd6746518852;
   localparam logic signed [AW-1:0] FX_PI      = 36'sd3373259426;
   localparam logic signed [AW-1:0] FX_HALF_PI = 36'sd1686629713;
   localparam logic signed [31:0]   FX_KINV    = 32'sd652032874;

   localparam int IN_TDATA_W  = 264;
   localparam int OUT_TDATA_W = 192;
   localparam int CSR_INDEX_W = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRIFT_GAIN = 8'd0,
      CSR_TRANS_GAIN = 8'd1,
      CSR_ROT_GAIN   = 8'd2,
      CSR_INV_DT     = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0] drift_gain;
      logic [31:0] trans_noise_gain;
      logic [31:0] rot_noise_gain;
      logic [31:0] inv_dt;
   } brap_cfg_type;

   // One classified particle: the draws are already centered around zero.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] dip_x;
      logic signed [31:0] dip_y;
      logic signed [23:0] c_x;
      logic signed [23:0] c_y;
      logic signed [23:0] c_a;
      logic               upd;
   } brap_item_type;

   // Fields that ride along the back pipeline untouched by the rotation.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] dip_x;
      logic signed [31:0] dip_y;
      logic               upd;
   } brap_carry_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // atan(2^-i) in Q.30, rounded.
   function automatic logic signed [AW-1:0] atan_q30(input int unsigned i);
      logic signed [AW-1:0] a;
      case (i)
         0: a = 36'sd843314857;
         1: a = 36'sd497837829;
         2: a = 36'sd263043837;
         3: a = 36'sd133525159;
         4: a = 36'sd67021687;
         5: a = 36'sd33543516;
         6: a = 36'sd16775851;
         7: a = 36'sd8388437;
         8: a = 36'sd4194283;
         9: a = 36'sd2097149;
         default: a = (i < 31) ? (36'sd1 <<< (30 - i)) : 36'sd0;
      endcase
      return a;
   endfunction

endpackage

// File: src/brap_front.sv
// Front stage: takes particles off the input stream, centers the random draws
// and hands classified items to the queue. Depends on brap_pkg.
`timescale 1ns / 1ps
module brap_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [brap_pkg::IN_TDATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   output logic                           push_valid,
   input  logic                           push_ready,
   output brap_pkg::brap_item_type        push_item
);
   import brap_pkg::*;

   logic          valid_ff, valid_in;
   brap_item_type item_ff, item_in;

   assign req_tready = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      item_in.pos_x   = req_tdata[31:0];
      item_in.pos_y   = req_tdata[63:32];
      item_in.force_x = req_tdata[95:64];
      item_in.force_y = req_tdata[127:96];
      item_in.dip_x   = req_tdata[159:128];
      item_in.dip_y   = req_tdata[191:160];
      // rand - 2^23 fits a signed 24-bit value: flip the top bit.
      item_in.c_x     = {~req_tdata[215], req_tdata[214:192]};
      item_in.c_y     = {~req_tdata[239], req_tdata[238:216]};
      item_in.c_a     = {~req_tdata[263], req_tdata[262:240]};
      item_in.upd     = req_tuser;
      valid_in        = req_tready ? req_tvalid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end
endmodule

// File: src/brap_queue.sv
// Short queue between the front and the back pipeline, so each side can stall
// on its own. Depends on brap_pkg for the item type.
`timescale 1ns / 1ps
module brap_queue #(
   parameter int DEPTH = brap_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  brap_pkg::brap_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output brap_pkg::brap_item_type pop_item
);
   import brap_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   brap_item_type mem_ff [0:DEPTH-1];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end
endmodule

// File: src/brap_back.sv
// Back pipeline: displacement, velocity, angle reduction and the pipelined
// CORDIC rotator, ending in the output register. Depends on brap_pkg.
`timescale 1ns / 1ps
module brap_back #(
   parameter int CORDIC_STAGES = brap_pkg::CORDIC_STAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  brap_pkg::brap_cfg_type           cfg,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  brap_pkg::brap_item_type          pop_item,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [brap_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tuser
);
   import brap_pkg::*;

   localparam int NS = (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;

   logic en;

   // Stage 1: products.
   logic                v1_ff;
   brap_carry_type      c1_ff, c1_in;
   logic signed [64:0]  pdx1_ff, pdy1_ff, pdx1_in, pdy1_in;
   logic signed [56:0]  pnx1_ff, pny1_ff, pa1_ff, pnx1_in, pny1_in, pa1_in;

   // Stage 2: displacement and raw angle.
   logic                v2_ff;
   brap_carry_type      c2_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff, dx2_in, dy2_in;
   logic signed [ZW-1:0] z2_ff, z2_in;

   // Stage 3 and reduction stages.
   logic                red_v_ff   [0:REDUCE_STEPS];
   brap_carry_type      red_c_ff   [0:REDUCE_STEPS];
   logic [ZW-1:0]       red_r_ff   [0:REDUCE_STEPS];
   logic                red_neg_ff [0:REDUCE_STEPS];
   brap_carry_type      c3_in;
   logic [ZW-1:0]       r3_in;

   // Fold stage.
   logic                vf_ff;
   brap_carry_type      cf_ff;
   logic signed [AW-1:0] zf_ff, zf_in;
   logic signed [32:0]  mxf_ff, myf_ff, mxf_in, myf_in;
   logic signed [64:0]  pvx_ff, pvy_ff, pvx_in, pvy_in;

   // Gain compensation stage.
   logic                vg_ff;
   brap_carry_type      cg_ff, cg_in;
   logic signed [AW-1:0] zg_ff;
   logic signed [64:0]  pkx_ff, pky_ff, pkx_in, pky_in;

   // CORDIC stages; index 0 is the scaled vector.
   logic                 cr_v_ff [0:NS];
   brap_carry_type       cr_c_ff [0:NS];
   logic signed [XW-1:0] cr_x_ff [0:NS];
   logic signed [XW-1:0] cr_y_ff [0:NS];
   logic signed [AW-1:0] cr_z_ff [0:NS];
   logic signed [64:0]   sx0_in, sy0_in;

   // Output register.
   logic                     ov_ff;
   logic [OUT_TDATA_W-1:0]   od_ff, od_in;
   logic                     ou_ff;
   logic signed [XW-1:0]     rxo, ryo;

   assign en         = !ov_ff || rsp_tready;
   assign pop_ready  = en;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ou_ff;

   // ---------------- stage 1 ----------------
   always_comb begin
      c1_in.pos_x = pop_item.pos_x;
      c1_in.pos_y = pop_item.pos_y;
      c1_in.vel_x = '0;
      c1_in.vel_y = '0;
      c1_in.dip_x = pop_item.dip_x;
      c1_in.dip_y = pop_item.dip_y;
      c1_in.upd   = pop_item.upd;
      pdx1_in = pop_item.force_x * $signed({1'b0, cfg.drift_gain});
      pdy1_in = pop_item.force_y * $signed({1'b0, cfg.drift_gain});
      pnx1_in = $signed({1'b0, cfg.trans_noise_gain}) * pop_item.c_x;
      pny1_in = $signed({1'b0, cfg.trans_noise_gain}) * pop_item.c_y;
      pa1_in  = $signed({1'b0, cfg.rot_noise_gain}) * pop_item.c_a;
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      logic signed [64:0] drx, dry;
      logic signed [56:0] nzx, nzy, za;
      drx = (pdx1_ff + 65'sd32768) >>> 16;
      dry = (pdy1_ff + 65'sd32768) >>> 16;
      nzx = (pnx1_ff + 57'sd8388608) >>> 24;
      nzy = (pny1_ff + 57'sd8388608) >>> 24;
      za  = (pa1_ff + 57'sd512) >>> 10;
      if (c1_ff.upd) begin
         dx2_in = drx[DW-1:0] + nzx[DW-1:0];
         dy2_in = dry[DW-1:0] + nzy[DW-1:0];
      end else begin
         dx2_in = '0;
         dy2_in = '0;
      end
      z2_in = za[ZW-1:0];
   end

   // ---------------- stage 3 ----------------
   always_comb begin
      c3_in       = c2_ff;
      c3_in.pos_x = sat32(64'(c2_ff.pos_x) + 64'(dx2_ff));
      c3_in.pos_y = sat32(64'(c2_ff.pos_y) + 64'(dy2_ff));
      // The velocity slot holds the saturated displacement until the fold stage.
      c3_in.vel_x = sat32(64'(dx2_ff));
      c3_in.vel_y = sat32(64'(dy2_ff));
      r3_in       = z2_ff[ZW-1] ? ZW'(-z2_ff) : ZW'(z2_ff);
   end

   // ---------------- fold stage ----------------
   always_comb begin
      logic signed [AW-1:0] zs;
      logic                 flip;
      zs = red_neg_ff[REDUCE_STEPS] ? -$signed(AW'(red_r_ff[REDUCE_STEPS]))
                                    : $signed(AW'(red_r_ff[REDUCE_STEPS]));
      if (zs > FX_PI) zs = zs - FX_TWO_PI_S;
      if (zs < -FX_PI) zs = zs + FX_TWO_PI_S;
      flip = 1'b0;
      if (zs > FX_HALF_PI) begin
         zs   = zs - FX_PI;
         flip = 1'b1;
      end else if (zs < -FX_HALF_PI) begin
         zs   = zs + FX_PI;
         flip = 1'b1;
      end
      zf_in  = zs;
      mxf_in = flip ? -33'(red_c_ff[REDUCE_STEPS].dip_x) : 33'(red_c_ff[REDUCE_STEPS].dip_x);
      myf_in = flip ? -33'(red_c_ff[REDUCE_STEPS].dip_y) : 33'(red_c_ff[REDUCE_STEPS].dip_y);
      pvx_in = red_c_ff[REDUCE_STEPS].vel_x * $signed({1'b0, cfg.inv_dt});
      pvy_in = red_c_ff[REDUCE_STEPS].vel_y * $signed({1'b0, cfg.inv_dt});
   end

   // ---------------- gain stage ----------------
   always_comb begin
      logic signed [64:0] rvx, rvy;
      rvx = (pvx_ff + 65'sd32768) >>> 16;
      rvy = (pvy_ff + 65'sd32768) >>> 16;
      cg_in       = cf_ff;
      cg_in.vel_x = sat32(rvx[63:0]);
      cg_in.vel_y = sat32(rvy[63:0]);
      pkx_in = 65'(mxf_ff) * 65'(FX_KINV);
      pky_in = 65'(myf_ff) * 65'(FX_KINV);
   end

   // Scaled vector, rounded to Q.30 with guard bits.
   always_comb begin
      sx0_in = (pkx_ff + 65'sd32768) >>> 16;
      sy0_in = (pky_ff + 65'sd32768) >>> 16;
   end

   // ---------------- output ----------------
   always_comb begin
      logic signed [31:0] ndx, ndy;
      rxo = (cr_x_ff[NS] + XW'(8192)) >>> 14;
      ryo = (cr_y_ff[NS] + XW'(8192)) >>> 14;
      if (cr_c_ff[NS].upd) begin
         ndx = sat32(64'(rxo));
         ndy = sat32(64'(ryo));
      end else begin
         ndx = cr_c_ff[NS].dip_x;
         ndy = cr_c_ff[NS].dip_y;
      end
      od_in = {ndy, ndx, cr_c_ff[NS].vel_y, cr_c_ff[NS].vel_x,
               cr_c_ff[NS].pos_y, cr_c_ff[NS].pos_x};
   end

   // ---------------- valid chain ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         red_v_ff[0]   <= 1'b0;
         vf_ff         <= 1'b0;
         vg_ff         <= 1'b0;
         cr_v_ff[0]    <= 1'b0;
         ov_ff         <= 1'b0;
      end else if (en) begin
         v1_ff         <= pop_valid;
         v2_ff         <= v1_ff;
         red_v_ff[0]   <= v2_ff;
         vf_ff         <= red_v_ff[REDUCE_STEPS];
         vg_ff         <= vf_ff;
         cr_v_ff[0]    <= vg_ff;
         ov_ff         <= cr_v_ff[NS];
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff   <= c1_in;
         pdx1_ff <= pdx1_in;
         pdy1_ff <= pdy1_in;
         pnx1_ff <= pnx1_in;
         pny1_ff <= pny1_in;
         pa1_ff  <= pa1_in;

         c2_ff  <= c1_ff;
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;
         z2_ff  <= z2_in;

         red_c_ff[0]   <= c3_in;
         red_r_ff[0]   <= r3_in;
         red_neg_ff[0] <= z2_ff[ZW-1];

         cf_ff  <= red_c_ff[REDUCE_STEPS];
         zf_ff  <= zf_in;
         mxf_ff <= mxf_in;
         myf_ff <= myf_in;
         pvx_ff <= pvx_in;
         pvy_ff <= pvy_in;

         cg_ff  <= cg_in;
         zg_ff  <= zf_ff;
         pkx_ff <= pkx_in;
         pky_ff <= pky_in;

         cr_c_ff[0] <= cg_ff;
         cr_x_ff[0] <= sx0_in[XW-1:0];
         cr_y_ff[0] <= sy0_in[XW-1:0];
         cr_z_ff[0] <= zg_ff;

         od_ff <= od_in;
         ou_ff <= cr_c_ff[NS].upd;
      end
   end

   // Angle reduction: one conditional subtract of 2*pi*2^(REDUCE_STEPS-1-k) per stage, largest first.
   for (genvar k = 0; k < REDUCE_STEPS; k++) begin : g_reduce
      localparam logic [ZW-1:0] STEP = FX_TWO_PI << (REDUCE_STEPS - 1 - k);
      always_ff @(posedge clock) begin
         if (reset) begin
            red_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            red_v_ff[k+1] <= red_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            red_c_ff[k+1]   <= red_c_ff[k];
            red_neg_ff[k+1] <= red_neg_ff[k];
            red_r_ff[k+1]   <= (red_r_ff[k] >= STEP) ? red_r_ff[k] - STEP : red_r_ff[k];
         end
      end
   end

   // CORDIC rotation stages.
   for (genvar i = 0; i < NS; i++) begin : g_cordic
      localparam logic signed [AW-1:0] ATAN = atan_q30(i);
      logic signed [XW-1:0] xs, ys;
      assign xs = cr_x_ff[i] >>> i;
      assign ys = cr_y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (reset) begin
            cr_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            cr_v_ff[i+1] <= cr_v_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cr_c_ff[i+1] <= cr_c_ff[i];
            if (!cr_z_ff[i][AW-1]) begin
               cr_x_ff[i+1] <= cr_x_ff[i] - ys;
               cr_y_ff[i+1] <= cr_y_ff[i] + xs;
               cr_z_ff[i+1] <= cr_z_ff[i] - ATAN;
            end else begin
               cr_x_ff[i+1] <= cr_x_ff[i] + ys;
               cr_y_ff[i+1] <= cr_y_ff[i] - xs;
               cr_z_ff[i+1] <= cr_z_ff[i] + ATAN;
            end
         end
      end
   end
endmodule

// File: src/brownian_active_particle_step_unit.sv
// Throughput: one item per cycle; the back pipeline advances as one unit and
// stalls only while the output register holds an item that is not taken.
// Reset is synchronous and active high; it empties the pipeline and the queue
// and restores the registers to drift and noise gains of zero and inv_dt of 1.0.
`timescale 1ns / 1ps
module brownian_active_particle_step_unit #(
   parameter int CORDIC_STAGES = brap_pkg::CORDIC_STAGES_DEF,
   parameter int QUEUE_DEPTH   = brap_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: pos_x, pos_y, force_x, force_y, dipole_x, dipole_y (32 bits each),
   // then rand_x, rand_y, rand_angle (24 bits each), from the lowest bit up.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [brap_pkg::IN_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,   // in_group
   // tdata: new_pos_x, new_pos_y, vel_x, vel_y, new_dipole_x, new_dipole_y,
   // 32 bits each, from the lowest bit up.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [brap_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tuser,   // updated
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [brap_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata
);
   import brap_pkg::*;

   // Configuration registers. Writes to an index beyond the list are dropped.
   brap_cfg_type  cfg_ff, cfg_in;

   // Front to queue and queue to back handshakes.
   logic          push_valid, push_ready, pop_valid, pop_ready;
   brap_item_type push_item, pop_item;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DRIFT_GAIN: cfg_in.drift_gain       = csr_wdata;
            CSR_TRANS_GAIN: cfg_in.trans_noise_gain = csr_wdata;
            CSR_ROT_GAIN:   cfg_in.rot_noise_gain   = csr_wdata;
            CSR_INV_DT:     cfg_in.inv_dt           = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drift_gain       <= '0;
         cfg_ff.trans_noise_gain <= '0;
         cfg_ff.rot_noise_gain   <= '0;
         cfg_ff.inv_dt           <= 32'h0001_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front unpacks the item and centers the draws; it keeps accepting as
   // long as the queue has room, independent of the result side.
   brap_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   brap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // The back pipeline does all the arithmetic and ends in the output register.
   brap_back #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

// File: src/brap_checker.sv
// Port-level checks of the Brownian active particle step unit, bound to the
// top level. Depends on brap_pkg for the port widths.
`timescale 1ns / 1ps
module brap_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [brap_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);
   // A result waiting to be taken stays on the bus.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // A particle that was passed through shows zero velocity.
   a_vel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[127:64] == 64'd0)
      else $error("pass-through item with nonzero velocity");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule

bind brownian_active_particle_step_unit brap_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
